FILE: rtl/ocd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ocd_pkg;

  localparam int TRIG_BITS   = 10;
  localparam int QUARTER     = 1 << (TRIG_BITS - 2);
  localparam int FULL_TURN   = 92160;
  localparam int PITCH_LIMIT = 22784;
  localparam int RED_STEPS   = 1;
  localparam int PHS_STEPS   = 1;
  localparam int CNT_W       = 1;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // full-turn multiple above the largest negative yaw step
  localparam int YAW_BIAS = FULL_TURN * 8192;

  // reciprocal of a full turn for the yaw wrap quotient
  localparam int YAW_SHIFT = 47;
  localparam int YQ_W      = 14;
  localparam longint unsigned YAW_RECIP =
    ((64'd1 << YAW_SHIFT) + 64'(FULL_TURN) - 64'd1) / 64'(FULL_TURN);

  // reciprocal for the table phase of a wrapped angle
  localparam int PH_SHIFT = 34;
  localparam longint unsigned PH_RECIP =
    ((64'd1 << (PH_SHIFT + TRIG_BITS)) + 64'(FULL_TURN) - 64'd1) / 64'(FULL_TURN);

  localparam logic REG_DIST = 1'b0;
  localparam logic REG_SENS = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ANG, S_RED, S_PHS, S_TRIG, S_PROD, S_FIN
  } state_t;

  typedef struct packed {
    logic cap;
    logic mul;
    logic ang;
    logic red;
    logic phs_init;
    logic phs;
    logic trig;
    logic prod;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

  typedef logic [14:0] qtab_t [0:QUARTER];

  function automatic qtab_t build_qtab();
    qtab_t tab;
    longint unsigned x;
    longint unsigned t;
    longint sum;
    for (int m = 0; m <= QUARTER; m++) begin
      x = (longint'(m) * HALF_PI_Q30) >> (TRIG_BITS - 2);
      t = x;
      sum = longint'(x);
      for (int n = 1; n <= 5; n++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        case (n)
          1: t = t / 64'd6;
          2: t = t / 64'd20;
          3: t = t / 64'd42;
          4: t = t / 64'd72;
          default: t = t / 64'd110;
        endcase
        if ((n & 1) == 1) sum = sum - longint'(t);
        else sum = sum + longint'(t);
      end
      if (sum < 0) sum = 0;
      tab[m] = 15'((sum + 32768) >>> 16);
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  function automatic logic signed [15:0] sin_of(input logic [TRIG_BITS-1:0] k);
    logic [1:0] q;
    logic [TRIG_BITS-3:0] r;
    logic [TRIG_BITS-2:0] idx;
    logic [14:0] v;
    q = k[TRIG_BITS-1:TRIG_BITS-2];
    r = k[TRIG_BITS-3:0];
    idx = q[0] ? ((TRIG_BITS-1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
    v = QTAB[idx];
    return q[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ocd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ocd_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  ocd_pkg::sts_t    sts,
  output ocd_pkg::cmd_t    cmd
);
  import ocd_pkg::*;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ANG;
      end
      S_ANG: begin
        cmd.ang   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_RED;
      end
      S_RED: begin
        cmd.red = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(RED_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_PHS;
        end
      end
      S_PHS: begin
        if (cnt_r == '0) cmd.phs_init = 1'b1;
        else cmd.phs = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PHS_STEPS)) begin
          cnt_nxt   = '0;
          state_nxt = S_TRIG;
        end
      end
      S_TRIG: begin
        cmd.trig  = 1'b1;
        state_nxt = S_PROD;
      end
      S_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/ocd_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ocd_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  ocd_pkg::cmd_t           cmd,
  output ocd_pkg::sts_t           sts,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic signed [15:0] in_mouse_x,
  input  wire logic signed [15:0] in_mouse_y,
  input  wire logic               in_button_held,
  input  wire logic               in_reset_held,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [16:0]      out_pos_x,
  output logic signed [16:0]      out_pos_y,
  output logic signed [16:0]      out_pos_z,
  output logic [16:0]             out_yaw_now,
  output logic signed [15:0]      out_pitch_now
);
  import ocd_pkg::*;

  logic [15:0] dist_r;
  logic [11:0] sens_r;
  logic        drag_r;
  logic signed [15:0] last_x_r, last_y_r;
  logic [16:0] yaw_r;
  logic signed [15:0] pitch_r;

  logic signed [15:0] mx_r, my_r;
  logic btn_r, rkey_r;
  logic signed [29:0] dx_r, dy_r;
  logic [30:0] red_r;
  logic [YQ_W-1:0] yq_r;
  logic [16:0] rem_p_r;
  logic [TRIG_BITS-1:0] ky_r, kp_r;
  logic signed [15:0] sp_r, cp_r, sy_r, cy_r;
  logic signed [32:0] pc_r, ps_r;
  logic out_valid_r;
  logic signed [16:0] pos_x_r, pos_y_r, pos_z_r;
  logic [16:0] yaw_o_r;
  logic signed [15:0] pitch_o_r;

  // drag delta
  logic start;
  logic signed [16:0] ddx, ddy;
  logic signed [12:0] sens_s;
  always_comb begin
    start  = btn_r && !drag_r;
    sens_s = $signed({1'b0, sens_r});
    ddx    = '0;
    ddy    = '0;
    if (btn_r && !start) begin
      ddx = 17'(mx_r) - 17'(last_x_r);
      ddy = 17'(my_r) - 17'(last_y_r);
    end
  end

  // angle update
  logic signed [31:0] ysum, psum;
  logic signed [15:0] pnew;
  logic [30:0] yred0;
  always_comb begin
    ysum = 32'(signed'({1'b0, yaw_r})) + 32'(dx_r);
    psum = 32'(pitch_r) - 32'(dy_r);
    if (psum > 32'(PITCH_LIMIT)) pnew = 16'(PITCH_LIMIT);
    else if (psum < -32'(PITCH_LIMIT)) pnew = -16'(PITCH_LIMIT);
    else pnew = psum[15:0];
    if (ysum < 0) yred0 = 31'(ysum + 32'(YAW_BIAS));
    else yred0 = ysum[30:0];
    if (rkey_r) begin
      yred0 = '0;
      pnew  = '0;
    end
  end

  // yaw wrap by reciprocal quotient
  logic [61:0] yprod;
  logic [30:0] ysub;
  logic [16:0] yaw_mod;
  always_comb begin
    yprod   = 62'(red_r) * 62'(YAW_RECIP);
    ysub    = red_r - 31'(yq_r) * 31'(FULL_TURN);
    yaw_mod = ysub[16:0];
  end

  // table phase by reciprocal
  logic [48:0] kyp, kpp;
  always_comb begin
    kyp = 49'(yaw_r) * 49'(PH_RECIP);
    kpp = 49'(rem_p_r) * 49'(PH_RECIP);
  end

  function automatic logic signed [16:0] rnd28(input logic signed [48:0] p);
    logic [48:0] mag;
    logic [20:0] m;
    mag = p[48] ? 49'(-p) : 49'(p);
    m = 21'((mag + (49'd1 << 27)) >> 28);
    return p[48] ? -$signed(m[16:0]) : $signed(m[16:0]);
  endfunction

  function automatic logic signed [16:0] rnd14(input logic signed [32:0] p);
    logic [32:0] mag;
    logic [18:0] m;
    mag = p[32] ? 33'(-p) : 33'(p);
    m = 19'((mag + (33'd1 << 13)) >> 14);
    return p[32] ? -$signed(m[16:0]) : $signed(m[16:0]);
  endfunction

  logic signed [48:0] px_full, pz_full;
  always_comb begin
    px_full = 49'(pc_r) * 49'(cy_r);
    pz_full = 49'(pc_r) * 49'(sy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r      <= 16'd2560;
      sens_r      <= 12'd128;
      drag_r      <= 1'b0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      yaw_r       <= '0;
      pitch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DIST: dist_r <= cfg_data;
          REG_SENS: sens_r <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (cmd.mul) begin
        drag_r <= btn_r;
        if (btn_r) begin
          last_x_r <= mx_r;
          last_y_r <= my_r;
        end
      end
      if (cmd.ang) pitch_r <= pnew;
      if (cmd.phs_init) yaw_r <= yaw_mod;
      if (cmd.fin) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mx_r   <= in_mouse_x;
      my_r   <= in_mouse_y;
      btn_r  <= in_button_held;
      rkey_r <= in_reset_held;
    end
    if (cmd.mul) begin
      dx_r <= 30'(ddx * sens_s);
      dy_r <= 30'(ddy * sens_s);
    end
    if (cmd.ang) red_r <= yred0;
    if (cmd.red) yq_r <= yprod[YAW_SHIFT +: YQ_W];
    if (cmd.phs_init) begin
      rem_p_r <= pitch_r[15] ? 17'(32'(pitch_r) + 32'(FULL_TURN)) : 17'(pitch_r);
    end
    if (cmd.phs) begin
      ky_r <= kyp[PH_SHIFT +: TRIG_BITS];
      kp_r <= kpp[PH_SHIFT +: TRIG_BITS];
    end
    if (cmd.trig) begin
      sp_r <= sin_of(kp_r);
      cp_r <= sin_of(kp_r + TRIG_BITS'(QUARTER));
      sy_r <= sin_of(ky_r);
      cy_r <= sin_of(ky_r + TRIG_BITS'(QUARTER));
    end
    if (cmd.prod) begin
      pc_r <= $signed({1'b0, dist_r}) * cp_r;
      ps_r <= $signed({1'b0, dist_r}) * sp_r;
    end
    if (cmd.fin) begin
      pos_x_r   <= rnd28(px_full);
      pos_z_r   <= rnd28(pz_full);
      pos_y_r   <= rnd14(ps_r);
      yaw_o_r   <= yaw_r;
      pitch_o_r <= pitch_r;
    end
  end

  assign sts.out_busy  = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_pos_x     = pos_x_r;
  assign out_pos_y     = pos_y_r;
  assign out_pos_z     = pos_z_r;
  assign out_yaw_now   = yaw_o_r;
  assign out_pitch_now = pitch_o_r;

endmodule
`default_nettype wire

FILE: rtl/orbit_camera_drag_position.sv
`timescale 1ns / 1ps
`default_nettype none
// requests are handled one at a time: in_ready is high only in idle, after the previous
// result has been issued, and issuing waits while an older result still waits for out_ready
// steps: delta multiply, angle update, yaw wrap quotient, wrap and phase multiply,
// trig lookup, two position products
// reset: synchronous active-low rst_n clears angles, drag state and restores
// distance 2560 and sensitivity 128
module orbit_camera_drag_position (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_mouse_x,
  input  wire logic signed [15:0] in_mouse_y,
  input  wire logic               in_button_held,
  input  wire logic               in_reset_held,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [16:0]      out_pos_x,
  output logic signed [16:0]      out_pos_y,
  output logic signed [16:0]      out_pos_z,
  output logic [16:0]             out_yaw_now,
  output logic signed [15:0]      out_pitch_now,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import ocd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ocd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ocd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_mouse_x     (in_mouse_x),
    .in_mouse_y     (in_mouse_y),
    .in_button_held (in_button_held),
    .in_reset_held  (in_reset_held),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_pos_z      (out_pos_z),
    .out_yaw_now    (out_yaw_now),
    .out_pitch_now  (out_pitch_now)
  );

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import ocd_pkg::*;

  typedef struct packed {
    logic signed [16:0] px;
    logic signed [16:0] py;
    logic signed [16:0] pz;
    logic [16:0]        yaw;
    logic signed [15:0] pitch;
  } cam_pos_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               btn;
    logic               rkey;
    bit                 typed;
    cam_pos_t           want;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_mouse_x = '0;
  logic signed [15:0] in_mouse_y = '0;
  logic in_button_held = 1'b0;
  logic in_reset_held = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [16:0] out_pos_x, out_pos_y, out_pos_z;
  logic [16:0] out_yaw_now;
  logic signed [15:0] out_pitch_now;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_DIST;
  logic [15:0] cfg_data = '0;

  orbit_camera_drag_position dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mouse_x(in_mouse_x), .in_mouse_y(in_mouse_y),
    .in_button_held(in_button_held), .in_reset_held(in_reset_held),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_yaw_now(out_yaw_now), .out_pitch_now(out_pitch_now),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state
  longint qsin[0:256];
  bit     drag_on;
  longint anchor_x, anchor_y, yaw_q8, pitch_q8;
  longint dist_reg, sens_reg;

  cam_pos_t pending_pos[$];
  sample_row_t directed_rows[$];
  int mismatches = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int stall_cycles = 0;

  function automatic longint quarter_wave(longint m);
    longint unsigned x, t;
    longint sum;
    x = (longint'(m) * 64'd1686629713) >> 8;
    t = x;
    sum = longint'(x);
    for (int n = 1; n <= 5; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - longint'(t);
      else sum = sum + longint'(t);
    end
    if (sum < 0) sum = 0;
    return (sum + 32768) >>> 16;
  endfunction

  function automatic longint sin_at(longint k);
    longint q, r, v;
    k = k & 1023;
    q = k >> 8;
    r = k & 255;
    v = (q & 1) ? qsin[256 - r] : qsin[r];
    return (q & 2) ? -v : v;
  endfunction

  function automatic longint angle_phase(longint a);
    longint w;
    w = a % 92160;
    if (w < 0) w += 92160;
    return (w << 10) / 92160;
  endfunction

  function automatic longint round_away(longint p, int sh);
    longint mag;
    mag = (p < 0) ? -p : p;
    mag = (mag + (longint'(1) << (sh - 1))) >> sh;
    return (p < 0) ? -mag : mag;
  endfunction

  function automatic cam_pos_t orbit_step(longint mx, longint my, bit btn, bit rkey);
    cam_pos_t r;
    longint kp, ky, sp, cp, sy, cy;
    if (btn && !drag_on) begin
      drag_on = 1;
      anchor_x = mx;
      anchor_y = my;
    end else if (!btn && drag_on) begin
      drag_on = 0;
    end
    if (drag_on) begin
      yaw_q8 = (yaw_q8 + (mx - anchor_x) * sens_reg) % 92160;
      if (yaw_q8 < 0) yaw_q8 += 92160;
      pitch_q8 = pitch_q8 - (my - anchor_y) * sens_reg;
      if (pitch_q8 > 22784) pitch_q8 = 22784;
      if (pitch_q8 < -22784) pitch_q8 = -22784;
      anchor_x = mx;
      anchor_y = my;
    end
    if (rkey) begin
      yaw_q8 = 0;
      pitch_q8 = 0;
    end
    kp = angle_phase(pitch_q8);
    ky = angle_phase(yaw_q8);
    sp = sin_at(kp);
    cp = sin_at(kp + 256);
    sy = sin_at(ky);
    cy = sin_at(ky + 256);
    r.px = 17'(round_away(dist_reg * cp * cy, 28));
    r.py = 17'(round_away(dist_reg * sp, 14));
    r.pz = 17'(round_away(dist_reg * cp * sy, 28));
    r.yaw = 17'(yaw_q8);
    r.pitch = 16'(pitch_q8);
    return r;
  endfunction

  task automatic add_row(int x, int y, bit btn, bit rkey, bit typed = 0,
                         cam_pos_t want = '0);
    sample_row_t s;
    s.x = 16'(x); s.y = 16'(y); s.btn = btn; s.rkey = rkey;
    s.typed = typed; s.want = want;
    directed_rows.push_back(s);
  endtask

  task automatic send_request(logic signed [15:0] x, logic signed [15:0] y, bit btn,
                              bit rkey, bit typed = 0, cam_pos_t want = '0);
    cam_pos_t p;
    int gap;
    gap = ($urandom_range(99) < send_idle) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mouse_x <= x;
    in_mouse_y <= y;
    in_button_held <= btn;
    in_reset_held <= rkey;
    do @(posedge clk); while (!in_ready);
    p = orbit_step(longint'(x), longint'(y), btn, rkey);
    pending_pos.push_back(typed ? want : p);
  endtask

  task automatic drain_requests();
    if (in_valid) in_valid <= 1'b0;
    while (pending_pos.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_DIST) dist_reg = val;
    else sens_reg = val & 16'h0FFF;
  endtask

  task automatic random_phase(int count);
    logic signed [15:0] cx, cy;
    bit btn, rkey;
    int r;
    cx = 16'($urandom);
    cy = 16'($urandom);
    btn = 0;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 10) begin
        cx = 16'($urandom);
        cy = 16'($urandom);
      end else begin
        cx = cx + 16'($signed($urandom_range(0, 60)) - 30);
        cy = cy + 16'($signed($urandom_range(0, 60)) - 30);
      end
      if ($urandom_range(99) < 10) btn = ~btn;
      rkey = ($urandom_range(99) < 4);
      if ($urandom_range(99) < 2) drain_requests();
      send_request(cx, cy, btn, rkey);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    cam_pos_t got, exp_pos;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_pos_x, out_pos_y, out_pos_z, out_yaw_now, out_pitch_now};
      if (pending_pos.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected position: %p", got);
      end else begin
        exp_pos = pending_pos.pop_front();
        if (got !== exp_pos) begin
          mismatches++;
          if (mismatches <= 10)
            $display("position mismatch: exp x %0d y %0d z %0d yaw %0d pitch %0d, got x %0d y %0d z %0d yaw %0d pitch %0d",
                     exp_pos.px, exp_pos.py, exp_pos.pz, exp_pos.yaw, exp_pos.pitch,
                     got.px, got.py, got.pz, got.yaw, got.pitch);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 5000) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    cam_pos_t home;
    for (int m = 0; m <= 256; m++) qsin[m] = quarter_wave(m);
    drag_on = 0; anchor_x = 0; anchor_y = 0; yaw_q8 = 0; pitch_q8 = 0;
    dist_reg = 2560; sens_reg = 128;
    home = '{17'sd2560, 17'sd0, 17'sd0, 17'd0, 16'sd0};

    add_row(0, 0, 0, 0, 1, home);
    add_row(-32768, 32767, 1, 0, 1, home);
    add_row(32767, -32768, 1, 0);
    add_row(-32768, 32767, 1, 0);
    add_row(-32768, 32767, 1, 1, 1, home);
    add_row(-32767, 32767, 1, 0);
    add_row(-32767, 32766, 1, 0);
    add_row(0, 0, 0, 0);
    add_row(100, 100, 0, 0);
    add_row(100, 100, 1, 1, 1, home);
    add_row(90, 110, 1, 0);
    add_row(90, 110, 0, 1, 1, home);
    add_row(0, 0, 1, 0, 1, home);
    add_row(0, -178, 1, 0);
    add_row(0, -179, 1, 0);
    add_row(0, 356, 1, 0);
    add_row(720, 0, 1, 0);
    add_row(-1, 0, 1, 0);
    add_row(-1, 0, 0, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 14; recv_idle = 62;
    foreach (directed_rows[i])
      send_request(directed_rows[i].x, directed_rows[i].y, directed_rows[i].btn,
                   directed_rows[i].rkey, directed_rows[i].typed, directed_rows[i].want);
    drain_requests();
    write_reg(REG_DIST, 16'hFFFF);
    write_reg(REG_SENS, 16'h0FFF);
    random_phase(120);

    send_idle = 62; recv_idle = 14;
    drain_requests();
    write_reg(REG_DIST, 16'h0000);
    write_reg(REG_SENS, 16'h0000);
    random_phase(60);
    drain_requests();
    write_reg(REG_DIST, 16'h0001);
    write_reg(REG_SENS, 16'h0001);
    random_phase(80);

    send_idle = 0; recv_idle = 0;
    drain_requests();
    write_reg(REG_DIST, 16'($urandom));
    write_reg(REG_SENS, 16'($urandom_range(0, 4095)));
    random_phase(120);
    drain_requests();
    write_reg(REG_DIST, 16'd2560);
    write_reg(REG_SENS, 16'd128);
    random_phase(120);

    drain_requests();
    if (mismatches == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

FILE: files.f
rtl/ocd_pkg.sv
rtl/ocd_ctrl.sv
rtl/ocd_dp.sv
rtl/orbit_camera_drag_position.sv
dv/tb_top.sv
